/* rtl/ebalu_pkg.sv */
`timescale 1ns / 1ps

package ebalu_pkg;

    typedef enum logic [4:0] {
        ACT_ADD     = 5'd0,
        ACT_ADC     = 5'd1,
        ACT_SUB     = 5'd2,
        ACT_SBC     = 5'd3,
        ACT_AND     = 5'd4,
        ACT_XOR     = 5'd5,
        ACT_OR      = 5'd6,
        ACT_CP      = 5'd7,
        ACT_INC     = 5'd8,
        ACT_DEC     = 5'd9,
        ACT_RLC     = 5'd10,
        ACT_RRC     = 5'd11,
        ACT_RL      = 5'd12,
        ACT_RR      = 5'd13,
        ACT_SLA     = 5'd14,
        ACT_SRA     = 5'd15,
        ACT_SWAP    = 5'd16,
        ACT_SRL     = 5'd17,
        ACT_BIT     = 5'd18,
        ACT_RES     = 5'd19,
        ACT_SET     = 5'd20,
        ACT_DAA     = 5'd21,
        ACT_RLCA    = 5'd22,
        ACT_RRCA    = 5'd23,
        ACT_RLA     = 5'd24,
        ACT_RRA     = 5'd25,
        ACT_ADD16   = 5'd26,
        ACT_ADD_SP  = 5'd27,
        ACT_LOAD_AF = 5'd28
    } t_action;

    // shift unit codes, shared by the prefixed group and the accumulator rotates
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    // flag nibble bit positions: Z N H C
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0] ACC_RESET   = 8'h01;
    localparam logic [3:0] FLAGS_RESET = 4'hB;

    localparam logic [3:0] DAA_LO_LIMIT = 4'd9;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

    typedef struct packed {
        t_action     action;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        logic [15:0] wide_left;
        logic [15:0] wide_right;
        logic        dest_is_acc;
    } t_alu_in;

    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] wide_result;
        logic [3:0]  flag_bits;
        logic [7:0]  acc_value;
        logic        write_back;
    } t_alu_out;

    // returns {carry_out, result}
    function automatic logic [8:0] shift_op(input logic [2:0] code, input logic [7:0] v,
                                            input logic cin);
        logic [8:0] r;
        r = '0;
        case (code)
            SH_RLC:  r = {v[7], v[6:0], v[7]};
            SH_RRC:  r = {v[0], v[0], v[7:1]};
            SH_RL:   r = {v[7], v[6:0], cin};
            SH_RR:   r = {v[0], cin, v[7:1]};
            SH_SLA:  r = {v[7], v[6:0], 1'b0};
            SH_SRA:  r = {v[0], v[7], v[7:1]};
            SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
            SH_SRL:  r = {v[0], 1'b0, v[7:1]};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ebalu_exec.sv */
`timescale 1ns / 1ps

module ebalu_exec (
    input  ebalu_pkg::t_alu_in  i_op,
    input  logic [7:0]          i_acc,
    input  logic [3:0]          i_flags,
    output ebalu_pkg::t_alu_out o_res
);
    import ebalu_pkg::*;

    logic        cin;
    logic        k_add;
    logic        k_sub;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [8:0]  sub_diff;
    logic [4:0]  sub_half;
    logic [7:0]  inc_val;
    logic [7:0]  dec_val;
    logic [4:0]  cb_diff;
    logic [4:0]  ra_diff;
    logic [8:0]  cb_shift;
    logic [8:0]  ra_shift;
    logic [7:0]  bit_mask;
    logic [16:0] w_sum;
    logic [12:0] w_half;
    logic [15:0] sp_sum;
    logic [8:0]  sp_lo;
    logic [4:0]  sp_half;
    logic        daa_lo_need;
    logic        daa_hi_need;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_val;
    logic        daa_c;

    logic [7:0]  res;
    logic [15:0] wide;
    logic [3:0]  f;
    logic [7:0]  a;
    logic        wb;

    assign cin   = i_flags[FLAG_C];
    assign k_add = (i_op.action == ACT_ADC) & cin;
    assign k_sub = (i_op.action == ACT_SBC) & cin;

    assign add_sum  = {1'b0, i_acc} + {1'b0, i_op.operand} + {8'b0, k_add};
    assign add_half = {1'b0, i_acc[3:0]} + {1'b0, i_op.operand[3:0]} + {4'b0, k_add};
    // top bit of the 9-bit difference is the borrow
    assign sub_diff = {1'b0, i_acc} - {1'b0, i_op.operand} - {8'b0, k_sub};
    assign sub_half = {1'b0, i_acc[3:0]} - {1'b0, i_op.operand[3:0]} - {4'b0, k_sub};

    assign inc_val = i_op.operand + 8'd1;
    assign dec_val = i_op.operand - 8'd1;

    assign cb_diff  = i_op.action - ACT_RLC;
    assign ra_diff  = i_op.action - ACT_RLCA;
    assign cb_shift = shift_op(cb_diff[2:0], i_op.operand, cin);
    assign ra_shift = shift_op({1'b0, ra_diff[1:0]}, i_acc, cin);

    assign bit_mask = 8'd1 << i_op.bit_index;

    assign w_sum  = {1'b0, i_op.wide_left} + {1'b0, i_op.wide_right};
    assign w_half = {1'b0, i_op.wide_left[11:0]} + {1'b0, i_op.wide_right[11:0]};

    assign sp_sum  = i_op.wide_left + {{8{i_op.operand[7]}}, i_op.operand};
    assign sp_lo   = {1'b0, i_op.wide_left[7:0]} + {1'b0, i_op.operand};
    assign sp_half = {1'b0, i_op.wide_left[3:0]} + {1'b0, i_op.operand[3:0]};

    // decimal adjust: add after an addition, subtract after a subtraction
    always_comb begin
        daa_lo_need = 1'b0;
        daa_hi_need = 1'b0;
        if (!i_flags[FLAG_N]) begin
            daa_lo_need = i_flags[FLAG_H] | (i_acc[3:0] > DAA_LO_LIMIT);
            daa_hi_need = i_flags[FLAG_C] | (i_acc > DAA_HI_LIMIT);
        end else begin
            daa_lo_need = i_flags[FLAG_H];
            daa_hi_need = i_flags[FLAG_C];
        end
        daa_adj = (daa_lo_need ? DAA_LO_ADJ : 8'h00) | (daa_hi_need ? DAA_HI_ADJ : 8'h00);
        daa_val = i_flags[FLAG_N] ? (i_acc - daa_adj) : (i_acc + daa_adj);
        daa_c   = i_flags[FLAG_N] ? i_flags[FLAG_C] : daa_hi_need;
    end

    always_comb begin
        res  = 8'h00;
        wide = 16'h0000;
        f    = i_flags;
        a    = i_acc;
        wb   = 1'b0;
        case (i_op.action)
            ACT_ADD, ACT_ADC: begin
                res = add_sum[7:0];
                f   = {res == 8'h00, 1'b0, add_half[4], add_sum[8]};
                a   = res;
                wb  = 1'b1;
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                res = sub_diff[7:0];
                f   = {res == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
                if (i_op.action != ACT_CP) begin
                    a  = res;
                    wb = 1'b1;
                end
            end
            ACT_AND: begin
                res = i_acc & i_op.operand;
                f   = {res == 8'h00, 1'b0, 1'b1, 1'b0};
                a   = res;
                wb  = 1'b1;
            end
            ACT_XOR: begin
                res = i_acc ^ i_op.operand;
                f   = {res == 8'h00, 3'b000};
                a   = res;
                wb  = 1'b1;
            end
            ACT_OR: begin
                res = i_acc | i_op.operand;
                f   = {res == 8'h00, 3'b000};
                a   = res;
                wb  = 1'b1;
            end
            ACT_INC: begin
                res = inc_val;
                f   = {res == 8'h00, 1'b0, i_op.operand[3:0] == 4'hF, cin};
                wb  = 1'b1;
                if (i_op.dest_is_acc) a = res;
            end
            ACT_DEC: begin
                res = dec_val;
                f   = {res == 8'h00, 1'b1, i_op.operand[3:0] == 4'h0, cin};
                wb  = 1'b1;
                if (i_op.dest_is_acc) a = res;
            end
            ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SWAP, ACT_SRL: begin
                res = cb_shift[7:0];
                f   = {res == 8'h00, 2'b00, cb_shift[8]};
                wb  = 1'b1;
                if (i_op.dest_is_acc) a = res;
            end
            ACT_BIT: begin
                res = i_op.operand;
                f   = {~|(i_op.operand & bit_mask), 1'b0, 1'b1, cin};
            end
            ACT_RES, ACT_SET: begin
                res = (i_op.action == ACT_RES) ? (i_op.operand & ~bit_mask)
                                               : (i_op.operand | bit_mask);
                wb  = 1'b1;
                if (i_op.dest_is_acc) a = res;
            end
            ACT_DAA: begin
                res = daa_val;
                f   = {daa_val == 8'h00, i_flags[FLAG_N], 1'b0, daa_c};
                a   = daa_val;
                wb  = 1'b1;
            end
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
                // accumulator rotates always clear Z
                res = ra_shift[7:0];
                f   = {3'b000, ra_shift[8]};
                a   = res;
                wb  = 1'b1;
            end
            ACT_ADD16: begin
                wide = w_sum[15:0];
                f    = {i_flags[FLAG_Z], 1'b0, w_half[12], w_sum[16]};
            end
            ACT_ADD_SP: begin
                wide = sp_sum;
                f    = {2'b00, sp_half[4], sp_lo[8]};
            end
            ACT_LOAD_AF: begin
                a    = i_op.wide_left[15:8];
                f    = i_op.wide_left[7:4];
                wide = {i_op.wide_left[15:4], 4'h0};
                res  = i_op.wide_left[15:8];
            end
            default: begin
                res = 8'h00;
            end
        endcase
    end

    assign o_res.result      = res;
    assign o_res.wide_result = wide;
    assign o_res.flag_bits   = f;
    assign o_res.acc_value   = a;
    assign o_res.write_back  = wb;

endmodule

/* rtl/eight_bit_alu_with_flags_unit.sv */
// An accepted item waits in the input register, then moves to the result register on the outputs.
// Throughput: one item per cycle unless the output stalls; the exec logic between the input
//   and result registers also updates the accumulator and flags, so the next item sees them.
// Reset (synchronous, active low): both stages empty, accumulator 0x01, flags 0xB.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_action,
    input  logic [7:0]  i_operand,
    input  logic [2:0]  i_bit_index,
    input  logic [15:0] i_wide_left,
    input  logic [15:0] i_wide_right,
    input  logic        i_dest_is_acc,
    // result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_result,
    output logic [15:0] o_wide_result,
    output logic [3:0]  o_flag_bits,
    output logic [7:0]  o_acc_value,
    output logic        o_write_back
);
    import ebalu_pkg::*;

    // input stage: holds one accepted item until the result register has room
    t_alu_in    r_in;
    logic       r_in_valid;
    t_alu_in    n_in;
    logic       n_in_valid;

    // architectural state: accumulator and Z N H C
    logic [7:0] r_acc;
    logic [3:0] r_flags;
    logic [7:0] n_acc;
    logic [3:0] n_flags;

    // result stage
    t_alu_out   r_out;
    logic       r_out_valid;
    t_alu_out   n_out;
    logic       n_out_valid;

    t_alu_out   exec_res;
    logic       out_free;
    logic       advance;
    logic       accept;

    ebalu_exec u_exec (
        .i_op    (r_in),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .o_res   (exec_res)
    );

    // the result register frees up when empty or when its item is taken
    assign out_free = !r_out_valid || !i_stall;
    // move the held item into the result register and commit its state
    assign advance  = r_in_valid && out_free;
    // stall input only when the input stage is full and cannot drain this cycle
    assign o_stall  = r_in_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_in        = r_in;
        n_in_valid  = r_in_valid;
        n_acc       = r_acc;
        n_flags     = r_flags;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (advance) begin
            n_out       = exec_res;
            n_out_valid = 1'b1;
            n_acc       = exec_res.acc_value;
            n_flags     = exec_res.flag_bits;
            n_in_valid  = 1'b0;
        end else if (!i_stall) begin
            // result taken and nothing to replace it: drop valid
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_in.action      = t_action'(i_action);
            n_in.operand     = i_operand;
            n_in.bit_index   = i_bit_index;
            n_in.wide_left   = i_wide_left;
            n_in.wide_right  = i_wide_right;
            n_in.dest_is_acc = i_dest_is_acc;
            n_in_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= ACC_RESET;
            r_flags     <= FLAGS_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_flags     <= n_flags;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_out.result;
    assign o_wide_result = r_out.wide_result;
    assign o_flag_bits   = r_out.flag_bits;
    assign o_acc_value   = r_out.acc_value;
    assign o_write_back  = r_out.write_back;

endmodule

/* rtl/ebalu_checker.sv */
`timescale 1ns / 1ps

module ebalu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_result,
    input logic [15:0] o_wide_result,
    input logic [3:0]  o_flag_bits,
    input logic [7:0]  o_acc_value,
    input logic        o_write_back
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input back-pressure only arises behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // register-writing operations never carry a 16-bit sum
    a_wb_no_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_back) |-> (o_wide_result == 16'h0000))
        else $error("write-back item with nonzero wide result");

    // a stalled result item holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result) && $stable(o_flag_bits)
                                  && $stable(o_acc_value) && $stable(o_wide_result)))
        else $error("stalled result item changed");

endmodule

bind eight_bit_alu_with_flags_unit ebalu_checker u_ebalu_checker (.*);

/* tb/tb_eight_bit_alu_with_flags_unit.sv */
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_flags_unit;
    import ebalu_pkg::*;

    // Codes past the last action: the block must leave its state alone.
    localparam logic [4:0] ACT_NONE_LO = 5'd29;
    localparam logic [4:0] ACT_NONE_HI = 5'd31;

    localparam int IDLE_LIMIT = 2000;  // cycles with no item moving on either side
    localparam int LONG_HOLD  = 48;    // receiver hold-off that fills the pipeline
    localparam int DRAIN_GAP  = 4;     // block latency plus margin

    // Action kept as a raw code so the unused codes can be driven too.
    typedef struct packed {
        logic [4:0]  action;
        logic [7:0]  operand;
        logic [2:0]  bit_index;
        logic [15:0] wide_left;
        logic [15:0] wide_right;
        logic        dest_is_acc;
    } t_op;

    // One stimulus row: the operation and, for a few rows, a typed-in result.
    typedef struct packed {
        t_op      op;
        logic     typed;
        t_alu_out want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [4:0]  i_action;
    logic [7:0]  i_operand;
    logic [2:0]  i_bit_index;
    logic [15:0] i_wide_left;
    logic [15:0] i_wide_right;
    logic        i_dest_is_acc;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_result;
    logic [15:0] o_wide_result;
    logic [3:0]  o_flag_bits;
    logic [7:0]  o_acc_value;
    logic        o_write_back;

    // Shadow copy of the accumulator and flags, advanced once per accepted item.
    logic [7:0]  model_acc   = ACC_RESET;
    logic [3:0]  model_flags = FLAGS_RESET;

    t_alu_out    pending_results[$];  // expected results, oldest first
    t_row        dir_tab[$];
    t_row        live_row;            // row currently on the input port
    int          fail_count  = 0;
    int          idle_cycles = 0;
    logic        tx_idle_en  = 1'b0;
    logic        rx_idle_en  = 1'b0;
    logic        hold_req    = 1'b0;

    eight_bit_alu_with_flags_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_operand     (i_operand),
        .i_bit_index   (i_bit_index),
        .i_wide_left   (i_wide_left),
        .i_wide_right  (i_wide_right),
        .i_dest_is_acc (i_dest_is_acc),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result),
        .o_wide_result (o_wide_result),
        .o_flag_bits   (o_flag_bits),
        .o_acc_value   (o_acc_value),
        .o_write_back  (o_write_back)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Shift and rotate unit: returns {carry out, value}.
    function automatic logic [8:0] rotate_byte(input logic [2:0] code, input logic [7:0] v,
                                               input logic cin);
        logic       cy;
        logic [7:0] r;
        cy = v[0];
        r  = v >> 1;
        case (code)
            SH_RLC:  begin cy = v[7]; r = (v << 1) | {7'd0, v[7]}; end
            SH_RRC:  r[7] = v[0];
            SH_RL:   begin cy = v[7]; r = (v << 1) | {7'd0, cin}; end
            SH_RR:   r[7] = cin;
            SH_SLA:  begin cy = v[7]; r = v << 1; end
            SH_SRA:  r[7] = v[7];
            SH_SWAP: begin cy = 1'b0; r = {v[3:0], v[7:4]}; end
            default: ;  // logical shift right: already in place
        endcase
        return {cy, r};
    endfunction

    // Execute one operation against the shadow state and return its result item.
    function automatic t_alu_out alu_apply(input t_op op);
        t_alu_out   o;
        logic [7:0] a;
        logic [7:0] v;
        logic [7:0] res;
        logic [7:0] adj;
        logic [3:0] f;
        logic [8:0] sum;
        logic [8:0] shifted;
        logic [4:0] half;
        logic [12:0] half16;
        logic [16:0] sum16;
        logic       cin;
        logic       k;
        logic       cy;
        a   = model_acc;
        f   = model_flags;
        v   = op.operand;
        cin = f[FLAG_C];
        res = 8'd0;
        o   = '0;
        case (op.action)
            ACT_ADD, ACT_ADC: begin
                k    = (op.action == ACT_ADC) ? cin : 1'b0;
                sum  = {1'b0, a} + {1'b0, v} + {8'd0, k};
                half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, k};
                res  = sum[7:0];
                f    = {res == 8'd0, 1'b0, half[4], sum[8]};
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                // the sign bit of the widened difference is the borrow
                k    = (op.action == ACT_SBC) ? cin : 1'b0;
                sum  = {1'b0, a} - {1'b0, v} - {8'd0, k};
                half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, k};
                res  = sum[7:0];
                f    = {res == 8'd0, 1'b1, half[4], sum[8]};
            end
            ACT_AND: begin res = a & v; f = {res == 8'd0, 3'b010}; end
            ACT_XOR: begin res = a ^ v; f = {res == 8'd0, 3'b000}; end
            ACT_OR:  begin res = a | v; f = {res == 8'd0, 3'b000}; end
            ACT_INC: begin
                res = v + 8'd1;
                f   = {res == 8'd0, 1'b0, v[3:0] == 4'hF, f[FLAG_C]};
            end
            ACT_DEC: begin
                res = v - 8'd1;
                f   = {res == 8'd0, 1'b1, v[3:0] == 4'h0, f[FLAG_C]};
            end
            ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA, ACT_SWAP, ACT_SRL: begin
                shifted = rotate_byte(3'(op.action - ACT_RLC), v, cin);
                res     = shifted[7:0];
                f       = {res == 8'd0, 2'b00, shifted[8]};
            end
            ACT_BIT: begin
                res = v;
                f   = {~v[op.bit_index], 2'b01, f[FLAG_C]};
            end
            ACT_RES: res = v & ~(8'd1 << op.bit_index);
            ACT_SET: res = v | (8'd1 << op.bit_index);
            ACT_DAA: begin
                adj = 8'd0;
                cy  = f[FLAG_C];
                if (!f[FLAG_N]) begin
                    if (f[FLAG_H] || a[3:0] > DAA_LO_LIMIT) adj = adj | DAA_LO_ADJ;
                    if (f[FLAG_C] || a > DAA_HI_LIMIT) begin
                        adj = adj | DAA_HI_ADJ;
                        cy  = 1'b1;
                    end
                    a = a + adj;
                end else begin
                    if (f[FLAG_H]) adj = adj | DAA_LO_ADJ;
                    if (f[FLAG_C]) adj = adj | DAA_HI_ADJ;
                    a = a - adj;
                end
                f   = {a == 8'd0, f[FLAG_N], 1'b0, cy};
                res = a;
            end
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
                // accumulator rotates never set Z
                shifted = rotate_byte(3'(op.action - ACT_RLCA), a, cin);
                res     = shifted[7:0];
                f       = {3'b000, shifted[8]};
            end
            ACT_ADD16: begin
                sum16         = {1'b0, op.wide_left} + {1'b0, op.wide_right};
                half16        = {1'b0, op.wide_left[11:0]} + {1'b0, op.wide_right[11:0]};
                o.wide_result = sum16[15:0];
                f             = {f[FLAG_Z], 1'b0, half16[12], sum16[16]};
            end
            ACT_ADD_SP: begin
                // flags come from the unsigned low byte sum, the word from the signed offset
                sum           = {1'b0, op.wide_left[7:0]} + {1'b0, v};
                half          = {1'b0, op.wide_left[3:0]} + {1'b0, v[3:0]};
                o.wide_result = op.wide_left + {{8{v[7]}}, v};
                f             = {2'b00, half[4], sum[8]};
            end
            ACT_LOAD_AF: begin
                a             = op.wide_left[15:8];
                f             = op.wide_left[7:4];
                o.wide_result = {op.wide_left[15:4], 4'h0};
                res           = a;
            end
            default: ;  // unused codes: report the state untouched
        endcase
        // destination and write-back rules per group
        case (op.action)
            ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC, ACT_AND, ACT_XOR, ACT_OR, ACT_DAA,
            ACT_RLCA, ACT_RRCA, ACT_RLA, ACT_RRA: begin
                a            = res;
                o.write_back = 1'b1;
            end
            ACT_INC, ACT_DEC, ACT_RLC, ACT_RRC, ACT_RL, ACT_RR, ACT_SLA, ACT_SRA,
            ACT_SWAP, ACT_SRL, ACT_RES, ACT_SET: begin
                if (op.dest_is_acc) a = res;
                o.write_back = 1'b1;
            end
            default: ;
        endcase
        model_acc   = a;
        model_flags = f;
        o.result    = res;
        o.flag_bits = f;
        o.acc_value = a;
        return o;
    endfunction

    function automatic t_row mk(input logic [4:0] act, input logic [7:0] v,
                                input logic [2:0] b, input logic [15:0] wl,
                                input logic [15:0] wr, input logic d,
                                input logic typed, input t_alu_out want);
        t_row r;
        r.op    = '{act, v, b, wl, wr, d};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Byte with extra weight on the corners that drive the half and full carries.
    function automatic logic [7:0] rand_byte();
        logic [7:0] x;
        x = 8'($urandom);
        case ($urandom_range(0, 7))
            0:       x = 8'h00;
            1:       x = 8'hFF;
            2:       x = {x[7:4], 4'hF};
            3:       x = {x[7:4], 4'h0};
            default: ;
        endcase
        return x;
    endfunction

    function automatic logic [15:0] rand_word();
        logic [15:0] x;
        x = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       x = 16'h0000;
            1:       x = 16'hFFFF;
            2:       x = {x[15:12], 12'hFFF};
            3:       x = {x[15:8], rand_byte()};
            default: ;
        endcase
        return x;
    endfunction

    function automatic t_row rand_row();
        t_op o;
        if ($urandom_range(0, 49) == 0) begin
            o.action = 5'($urandom_range(ACT_NONE_LO, ACT_NONE_HI));
        end else begin
            o.action = 5'($urandom_range(0, int'(ACT_LOAD_AF)));
        end
        o.operand     = rand_byte();
        o.bit_index   = 3'($urandom);
        o.wide_left   = rand_word();
        o.wide_right  = rand_word();
        o.dest_is_acc = 1'($urandom);
        return '{o, 1'b0, t_alu_out'('0)};
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic offer(input t_row r);
        i_valid       <= 1'b1;
        i_action      <= r.op.action;
        i_operand     <= r.op.operand;
        i_bit_index   <= r.op.bit_index;
        i_wide_left   <= r.op.wide_left;
        i_wide_right  <= r.op.wide_right;
        i_dest_is_acc <= r.op.dest_is_acc;
        live_row      <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_tx(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Random items; with idling allowed, re-roll both sides' idle mode every
    // hundred items so quiet stretches alternate with bursty ones.
    task automatic run_random(input int n, input logic allow_idle);
        int k;
        for (k = 0; k < n; k++) begin
            if (allow_idle && k % 100 == 0) begin
                tx_idle_en = 1'($urandom_range(0, 1));
                rx_idle_en = 1'($urandom_range(0, 1));
            end
            offer(rand_row());
            if (tx_idle_en && $urandom_range(0, 3) == 0) pause_tx($urandom_range(1, 17));
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Scoreboard: predict on every accepted input item, check every accepted
    // result item against the oldest prediction.
    always @(posedge i_clk) begin
        t_alu_out pred;
        t_alu_out want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pred = alu_apply(live_row.op);
                pending_results.push_back(live_row.typed ? live_row.want : pred);
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result with none expected, expected nothing, got %h",
                             $time, {o_result, o_wide_result, o_flag_bits, o_acc_value,
                                     o_write_back});
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result",      16'(want.result),     16'(o_result));
                    check_field("wide_result", want.wide_result,     o_wide_result);
                    check_field("flag_bits",   16'(want.flag_bits),  16'(o_flag_bits));
                    check_field("acc_value",   16'(want.acc_value),  16'(o_acc_value));
                    check_field("write_back",  16'(want.write_back), 16'(o_write_back));
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Watchdog: drop the run if nothing moves for too long.
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17) - 1) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Input side: reset, directed table, random phases, drain.
    initial begin
        int k;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= '0;
        i_operand     <= '0;
        i_bit_index   <= '0;
        i_wide_left   <= '0;
        i_wide_right  <= '0;
        i_dest_is_acc <= 1'b0;
        live_row      <= '0;

        // Rows with a typed result come first, while the state is easy to follow:
        // an unused code straight after reset, a full load of AF, the all-carry add,
        // the borrow out of zero and the 16-bit wrap. Then one row per remaining
        // operation (two for ADD_SP), checked against the shadow model.
        dir_tab.push_back(mk(ACT_NONE_HI, 8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0,
                             1'b1, '{8'h01 & 8'h00, 16'h0000, FLAGS_RESET, ACC_RESET, 1'b0}));
        dir_tab.push_back(mk(ACT_LOAD_AF, 8'h00, 3'd0, 16'hFFFF, 16'h0000, 1'b0,
                             1'b1, '{8'hFF, 16'hFFF0, 4'hF, 8'hFF, 1'b0}));
        dir_tab.push_back(mk(ACT_ADD, 8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0,
                             1'b1, '{8'h00, 16'h0000, 4'hB, 8'h00, 1'b1}));
        dir_tab.push_back(mk(ACT_SUB, 8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0,
                             1'b1, '{8'hFF, 16'h0000, 4'h7, 8'hFF, 1'b1}));
        dir_tab.push_back(mk(ACT_ADD16, 8'h00, 3'd0, 16'hFFFF, 16'h0001, 1'b0,
                             1'b1, '{8'h00, 16'h0000, 4'h3, 8'hFF, 1'b0}));
        dir_tab.push_back(mk(ACT_ADC,      8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SBC,      8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_AND,      8'hF0, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_XOR,      8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_OR,       8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_CP,       8'h55, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_INC,      8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_DEC,      8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RLC,      8'h80, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RRC,      8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RL,       8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RR,       8'h01, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SLA,      8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SRA,      8'h80, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SWAP,     8'hF0, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SRL,      8'h01, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_BIT,      8'h7F, 3'd7, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RES,      8'hFF, 3'd0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_SET,      8'h00, 3'd7, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk(ACT_DAA,      8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RLCA,     8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RRCA,     8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RLA,      8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_RRA,      8'h00, 3'd0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_ADD_SP,   8'h80, 3'd0, 16'h00FF, 16'h0000, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk(ACT_ADD_SP,   8'h7F, 3'd0, 16'hFFFF, 16'h0000, 1'b0, 1'b0, '0));

        // Hold reset, then release it once for the whole run.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table back to back.
        for (k = 0; k < dir_tab.size(); k++) offer(dir_tab[k]);

        // Bursty random traffic on both sides.
        run_random(300, 1'b1);

        // Fill the pipeline: hold the result side off while items keep coming.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        run_random(40, 1'b0);

        // Pause the sender until every expected result has come back.
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        run_random(300, 1'b1);

        // Last stretch at full rate with no idling on either side.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(260, 1'b0);

        // Drain, then allow the block's latency to pass before judging.
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
